FILE: design/photo_sensor_scan_filter_top_defines.svh
// ----------------------------------------------------------------------------
// Photo sensor scan filter assertion macros
// Shared assertion helpers for the photo sensor scan filter top level.
// ----------------------------------------------------------------------------
`ifndef PHOTO_SENSOR_SCAN_FILTER_TOP_DEFINES_SVH
`define PHOTO_SENSOR_SCAN_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PSSF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PSSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pssf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photo sensor scan filter package
// Widths, register codes and shared types for the scan filter.
// ----------------------------------------------------------------------------
package pssf_pkg;

   localparam int CHANNELS    = 8;
   localparam int CH_BITS     = $clog2(CHANNELS);
   localparam int SAMPLE_BITS = 10;
   localparam int ALPHA_BITS  = 9;
   localparam int Q_SHIFT     = 8;
   localparam int MIX_BITS    = SAMPLE_BITS + ALPHA_BITS + 1;
   localparam int CSR_BITS    = 10;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1 << Q_SHIFT);

   localparam logic [CH_BITS-1:0] CH_LAST        = CH_BITS'(CHANNELS - 1);
   localparam logic [CH_BITS-1:0] CH_INNER_LEFT  = CH_BITS'(5);
   localparam logic [CH_BITS-1:0] CH_INNER_RIGHT = CH_BITS'(6);
   localparam logic [CH_BITS-1:0] CH_DOWN        = CH_BITS'(7);

   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET = ALPHA_BITS'(102);
   localparam logic [SAMPLE_BITS-1:0] NOISE_RESET = SAMPLE_BITS'(20);
   localparam logic [SAMPLE_BITS-1:0] HOLD_RESET  = SAMPLE_BITS'(200);
   localparam logic [SAMPLE_BITS-1:0] INNER_RESET = SAMPLE_BITS'(600);

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int REQ_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_LEVEL_LSB  = CH_BITS;
   localparam int RSP_AMB_LSB    = RSP_LEVEL_LSB + SAMPLE_BITS;
   localparam int RSP_TOP_LSB    = RSP_AMB_LSB + SAMPLE_BITS;
   localparam int RSP_SECOND_LSB = RSP_TOP_LSB + CH_BITS;
   localparam int RSP_SEEN_BIT   = RSP_SECOND_LSB + CH_BITS;
   localparam int RSP_HELD_BIT   = RSP_SEEN_BIT + 1;
   localparam int RSP_FIELD_BITS = RSP_HELD_BIT + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ALPHA = 2'd0,
      REG_NOISE = 2'd1,
      REG_HOLD  = 2'd2,
      REG_INNER = 2'd3
   } csr_reg_type;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_CAPTURE = 1'b1
   } op_type;

   typedef logic [SAMPLE_BITS-1:0]           sample_type;
   typedef logic [CH_BITS-1:0]               chan_type;
   typedef sample_type [CHANNELS-1:0]        chan_array_type;

   typedef struct packed {
      logic [ALPHA_BITS-1:0] alpha;
      sample_type            noise;
      sample_type            hold;
      sample_type            inner;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      sample_type sample;
   } entry_type;

   typedef struct packed {
      logic       valid;
      chan_type   channel;
      sample_type level;
      sample_type ambient;
      logic       sweep_done;
   } stage_type;

   typedef struct packed {
      chan_type   channel;
      sample_type level;
      sample_type ambient;
      chan_type   top;
      chan_type   second;
      logic       seen;
      logic       held;
   } result_type;

endpackage

FILE: design/pssf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan filter front end
// Accepts requests, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
module pssf_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [pssf_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic                                   req_tuser,
   input  logic                                   pop_ready,
   output logic                                   q_valid,
   output pssf_pkg::entry_type                    q_entry
);
   import pssf_pkg::*;

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   entry_type            decoded;
   logic                 push;
   logic                 pop;

   always_comb begin
      decoded.op     = op_type'(req_tuser);
      decoded.sample = req_tdata[SAMPLE_BITS-1:0];
   end

   assign req_tready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_entry    = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: design/pssf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan filter back end
// Smooths each sample into its channel, removes ambient, captures ambient.
// ----------------------------------------------------------------------------
module pssf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  pssf_pkg::entry_type       q_entry,
   input  pssf_pkg::cfg_type         cfg,
   input  logic                      adv,
   output logic                      pop_ready,
   output pssf_pkg::stage_type       stage,
   output pssf_pkg::chan_array_type  values
);
   import pssf_pkg::*;

   chan_array_type        values_ff, values_in;
   chan_type              scan_ff, scan_in;
   sample_type            ambient_ff, ambient_in;
   logic                  valid_ff, valid_in;
   stage_type             stage_ff, stage_in;
   logic                  take;
   logic [ALPHA_BITS-1:0] a_sat;
   sample_type            prev;
   logic [MIX_BITS-1:0]   prod_prev;
   logic [MIX_BITS-1:0]   prod_new;
   logic [MIX_BITS-1:0]   mix_sum;
   sample_type            mix;
   sample_type            level;
   sample_type            amb_min;

   assign pop_ready = !valid_ff || adv;
   assign take      = q_valid && pop_ready;

   // alpha above one saturates to one
   always_comb begin
      a_sat     = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
      prev      = values_ff[scan_ff];
      prod_prev = MIX_BITS'(prev) * MIX_BITS'(a_sat);
      prod_new  = MIX_BITS'(q_entry.sample) * MIX_BITS'(ALPHA_ONE - a_sat);
      mix_sum   = prod_prev + prod_new;
      mix       = mix_sum[Q_SHIFT +: SAMPLE_BITS];
      if (ambient_ff == '0) begin
         level = q_entry.sample;
      end else if (mix > ambient_ff) begin
         level = mix - ambient_ff;
      end else begin
         level = '0;
      end
   end

   // ambient is the darkest of back, left and right
   always_comb begin
      amb_min = values_ff[0];
      if (values_ff[1] < amb_min) begin
         amb_min = values_ff[1];
      end
      if (values_ff[2] < amb_min) begin
         amb_min = values_ff[2];
      end
   end

   always_comb begin
      values_in  = values_ff;
      scan_in    = scan_ff;
      ambient_in = ambient_ff;
      valid_in   = valid_ff;
      stage_in   = stage_ff;
      if (take) begin
         valid_in = 1'b1;
         unique case (q_entry.op)
            OP_CAPTURE: begin
               ambient_in          = amb_min;
               stage_in.channel    = '0;
               stage_in.level      = '0;
               stage_in.ambient    = amb_min;
               stage_in.sweep_done = 1'b0;
            end
            OP_SAMPLE: begin
               values_in[scan_ff]  = level;
               scan_in             = (scan_ff == CH_LAST) ? '0 : scan_ff + CH_BITS'(1);
               stage_in.channel    = scan_ff;
               stage_in.level      = level;
               stage_in.ambient    = ambient_ff;
               stage_in.sweep_done = (scan_ff == CH_LAST);
            end
         endcase
      end else if (adv) begin
         valid_in = 1'b0;
      end
      stage_in.valid = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         values_ff  <= '0;
         scan_ff    <= '0;
         ambient_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         values_ff  <= values_in;
         scan_ff    <= scan_in;
         ambient_ff <= ambient_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   always_comb begin
      stage       = stage_ff;
      stage.valid = valid_ff;
   end

   assign values = values_ff;

endmodule

FILE: design/pssf_report.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan filter report stage
// Peak search at sweep end and the registered response output.
// ----------------------------------------------------------------------------
module pssf_report (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pssf_pkg::stage_type                  stage,
   input  pssf_pkg::chan_array_type             values,
   input  pssf_pkg::cfg_type                    cfg,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [pssf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 adv
);
   import pssf_pkg::*;

   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   result_type res_ff, res_in;
   chan_type   top;
   chan_type   second;
   logic       seen;
   logic       held;

   assign adv = !valid_ff || rsp_tready;

   // earliest channel wins ties, strict compares only
   always_comb begin
      top    = '0;
      second = CH_BITS'(1);
      for (int i = 1; i < CHANNELS; i++) begin
         if (values[i] > values[top]) begin
            second = top;
            top    = CH_BITS'(i);
         end else if (values[i] > values[second]) begin
            second = CH_BITS'(i);
         end
      end
      seen = (values[top] > cfg.noise);
      held = (values[CH_DOWN] >= cfg.hold) &&
             (values[CH_INNER_RIGHT] > cfg.inner) &&
             (values[CH_INNER_LEFT] > cfg.inner);
   end

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      res_in   = res_ff;
      if (adv) begin
         valid_in       = stage.valid;
         last_in        = stage.sweep_done;
         res_in.channel = stage.channel;
         res_in.level   = stage.level;
         res_in.ambient = stage.ambient;
         res_in.top     = stage.sweep_done ? top    : '0;
         res_in.second  = stage.sweep_done ? second : '0;
         res_in.seen    = stage.sweep_done && seen;
         res_in.held    = stage.sweep_done && held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      res_ff  <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, res_ff.held, res_ff.seen, res_ff.second,
                        res_ff.top, res_ff.ambient, res_ff.level, res_ff.channel};

endmodule

FILE: design/photo_sensor_scan_filter_top.sv
`timescale 1ns / 1ps
`include "photo_sensor_scan_filter_top_defines.svh"
// ----------------------------------------------------------------------------
// Photo sensor scan filter
// Eight-channel light sensor smoothing with ambient removal and peak report.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one request per converter sample: tuser is the command
//    (sample or ambient capture), tdata the raw 10-bit reading. Samples are
//    taken for channels 0..7 in round-robin order by an internal counter.
//  - rsp_* returns exactly one response per request. tlast marks a sweep
//    end (channel 7 updated); top/second channel and the seen/held flags
//    are only meaningful there and read zero otherwise.
//  - csr_* writes the four settings (alpha, noise, hold, inner thresholds);
//    write only while no request is in flight.
// Timing:
//  - Requests pass the queue, filter register and report register in turn.
//  - One request per cycle sustained while rsp_tready is high, through the
//    front queue (2 deep), filter stage (two 10x9 multiplies) and report
//    stage (7-step peak search).
//  - When rsp_tready is low the output holds, the filter stage fills, then
//    the 2-entry queue fills and req_tready drops.
//  - Synchronous reset clears channel values, scan counter, ambient level
//    and the pipeline; settings return to 102/20/200/600.
// ----------------------------------------------------------------------------
module photo_sensor_scan_filter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pssf_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // [9:0] sample
   input  logic                                 req_tuser,  // [0] command
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] channel, [12:3] level, [22:13] ambient_level, [25:23] top_channel,
   // [28:26] second_channel, [29] target_seen, [30] target_held
   output logic [pssf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,  // sweep_done
   // settings write port
   input  logic                                 csr_we,
   input  logic [pssf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pssf_pkg::CSR_BITS-1:0]        csr_wdata
);
   import pssf_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           q_valid;
   entry_type      q_entry;
   logic           pop_ready;
   logic           adv;
   stage_type      stage;
   chan_array_type values;

   // Settings registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_ALPHA: cfg_in.alpha = csr_wdata[ALPHA_BITS-1:0];
            REG_NOISE: cfg_in.noise = csr_wdata[SAMPLE_BITS-1:0];
            REG_HOLD:  cfg_in.hold  = csr_wdata[SAMPLE_BITS-1:0];
            REG_INNER: cfg_in.inner = csr_wdata[SAMPLE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha <= ALPHA_RESET;
         cfg_ff.noise <= NOISE_RESET;
         cfg_ff.hold  <= HOLD_RESET;
         cfg_ff.inner <= INNER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and decode, queue toward the filter
   pssf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop_ready  (pop_ready),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   // Back: smoothing, ambient removal, channel state
   pssf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .cfg       (cfg_ff),
      .adv       (adv),
      .pop_ready (pop_ready),
      .stage     (stage),
      .values    (values)
   );

   // Report: peak search on sweep end and output register
   pssf_report u_report (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .values     (values),
      .cfg        (cfg_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .adv        (adv)
   );

   // Checks
   `PSSF_ASSERT_IMPL(a_last_is_down, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[CH_BITS-1:0] == CH_LAST, "sweep end on wrong channel")
   `PSSF_ASSERT_IMPL(a_peak_zero_mid, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[RSP_HELD_BIT:RSP_TOP_LSB] == '0, "peak fields set outside sweep end")
   `PSSF_ASSERT_IMPL(a_peak_distinct, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[RSP_TOP_LSB +: CH_BITS] != rsp_tdata[RSP_SECOND_LSB +: CH_BITS], "top and second channel equal")
   `PSSF_ASSERT_NEXT(a_take_lands, clock, reset, q_valid && pop_ready, stage.valid, "popped request lost before filter stage")

endmodule

FILE: bench/tb_photo_sensor_scan_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photo sensor scan filter testbench
// Streams sample and ambient-capture requests through the scan filter under
// several settings and handshake pacing mixes. A local model of the smoothing,
// ambient removal and peak search predicts each response; the monitor checks
// every response field by field, in order, as it leaves the block.
// ----------------------------------------------------------------------------
module tb_photo_sensor_scan_filter_top;
   import pssf_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;          // two-stage pipeline plus margin
   localparam int RUN_LIMIT_NS  = 2_000_000;  // far above the slowest legal run
   localparam int Q_ONE         = 1 << Q_SHIFT;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

   typedef enum { STYLE_PLAIN, STYLE_BRIGHT, STYLE_DARK } sweep_style_type;

   // one expected response
   typedef struct {
      chan_type   channel;
      sample_type level;
      sample_type ambient;
      logic       sweep_done;
      chan_type   top;
      chan_type   second;
      logic       seen;
      logic       held;
   } sensor_report_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [CSR_BITS-1:0]      csr_wdata  = '0;

   photo_sensor_scan_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ------------------------------------------------------ model state
   // Mirrors the block: stored channel levels, scan counter, ambient level
   // and the four settings (reset values from the package).
   sample_type            model_level [CHANNELS] = '{default: '0};
   int                    model_scan    = 0;
   sample_type            model_ambient = '0;
   logic [ALPHA_BITS-1:0] cfg_alpha     = ALPHA_RESET;
   sample_type            cfg_noise     = NOISE_RESET;
   sample_type            cfg_hold      = HOLD_RESET;
   sample_type            cfg_inner     = INNER_RESET;

   // ------------------------------------------------------ bench state
   entry_type         pending_requests [$];   // waiting to be driven
   sensor_report_type expected_reports [$];   // predicted, not yet seen
   entry_type         in_flight;              // request currently on req_*

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int drain_point    = -1;   // accept count at which the sender pauses
   bit drain_hold     = 1'b0;

   int next_slot = 0;         // channel the next sample will land on
   sweep_style_type sweep_style = STYLE_PLAIN;

   int accepted    = 0;
   int captures    = 0;
   int checked     = 0;
   int sweeps      = 0;
   int held_sweeps = 0;
   int seen_sweeps = 0;
   int mismatches  = 0;

   // ------------------------------------------------------ predictor
   // Applies one request to the model and returns the response it causes.
   function automatic sensor_report_type filter_and_rank(entry_type req);
      sensor_report_type rpt;
      int weight;
      int mix;
      int lowest;
      int top;
      int second;
      int ch;
      rpt = '{default: '0};
      if (req.op == OP_CAPTURE) begin
         // ambient = darkest of back, left and right; counter stays put
         lowest = model_level[0];
         if (model_level[1] < lowest) lowest = model_level[1];
         if (model_level[2] < lowest) lowest = model_level[2];
         model_ambient = sample_type'(lowest);
      end else begin
         if (model_scan >= CHANNELS) model_scan = 0;
         rpt.channel = chan_type'(model_scan);
         if (model_ambient == '0) begin
            mix = int'(req.sample);
         end else begin
            // alpha saturates at one (sample then carries no weight)
            weight = (int'(cfg_alpha) > Q_ONE) ? Q_ONE : int'(cfg_alpha);
            mix = (int'(model_level[model_scan]) * weight +
                   int'(req.sample) * (Q_ONE - weight)) >> Q_SHIFT;
            mix = (mix > int'(model_ambient)) ? mix - int'(model_ambient) : 0;
         end
         model_level[model_scan] = sample_type'(mix);
         rpt.level = model_level[model_scan];
         if (model_scan == CHANNELS - 1) begin
            rpt.sweep_done = 1'b1;
            model_scan = 0;
            // strict compares: earliest channel wins a tie
            top    = 0;
            second = 1;
            for (ch = 1; ch < CHANNELS; ch++) begin
               if (model_level[ch] > model_level[top]) begin
                  second = top;
                  top    = ch;
               end else if (model_level[ch] > model_level[second]) begin
                  second = ch;
               end
            end
            rpt.top    = chan_type'(top);
            rpt.second = chan_type'(second);
            rpt.seen   = model_level[top] > cfg_noise;
            rpt.held   = model_level[CH_DOWN] >= cfg_hold &&
                         model_level[CH_INNER_RIGHT] > cfg_inner &&
                         model_level[CH_INNER_LEFT] > cfg_inner;
         end else begin
            model_scan++;
         end
      end
      rpt.ambient = model_ambient;
      return rpt;
   endfunction

   // ------------------------------------------------------ reporting
   task automatic report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch on response %0d: %s", $time, checked, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // ------------------------------------------------------ driver
   // Holds a request until accepted; the model is stepped at acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(filter_and_rank(in_flight));
            accepted++;
            if (in_flight.op == OP_CAPTURE) captures++;
            if (accepted == drain_point) drain_hold = 1'b1;
         end
         if (!req_tvalid || req_tready) begin
            if (drain_hold && expected_reports.size() == 0) drain_hold = 1'b0;
            if (pending_requests.size() != 0 && !drain_hold &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_tdata  <= REQ_DATA_BITS'(in_flight.sample);
               req_tuser  <= in_flight.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------ monitor
   always @(posedge clock) begin
      sensor_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_reports.pop_front();
               check_field("channel", rsp_tdata[RSP_LEVEL_LSB-1:0], want.channel);
               check_field("level", rsp_tdata[RSP_AMB_LSB-1:RSP_LEVEL_LSB], want.level);
               check_field("ambient_level", rsp_tdata[RSP_TOP_LSB-1:RSP_AMB_LSB],
                           want.ambient);
               check_field("sweep_done", rsp_tlast, want.sweep_done);
               check_field("top_channel", rsp_tdata[RSP_SECOND_LSB-1:RSP_TOP_LSB],
                           want.top);
               check_field("second_channel", rsp_tdata[RSP_SEEN_BIT-1:RSP_SECOND_LSB],
                           want.second);
               check_field("target_seen", rsp_tdata[RSP_SEEN_BIT], want.seen);
               check_field("target_held", rsp_tdata[RSP_HELD_BIT], want.held);
               check_field("padding", rsp_tdata[RSP_DATA_BITS-1:RSP_FIELD_BITS], 0);
               if (want.sweep_done) begin
                  sweeps++;
                  if (want.held) held_sweeps++;
                  if (want.seen) seen_sweeps++;
               end
            end
            checked++;
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------ stimulus helpers
   task automatic queue_request(op_type op, int sample);
      entry_type req;
      req.op     = op;
      req.sample = sample_type'(sample);
      pending_requests.push_back(req);
      // captures leave the scan counter where it is
      if (op == OP_SAMPLE) next_slot = (next_slot + 1) % CHANNELS;
   endtask

   // Sweeps with random content: plain, bright (inner and down lit, so the
   // held flag can fire) or dark (drives levels near zero, often followed by a
   // capture so ambient drops back near zero). Occasional stray captures.
   task automatic queue_random(int count);
      int pick;
      int sample;
      repeat (count) begin
         if (next_slot == 0) begin
            if (sweep_style == STYLE_DARK && $urandom_range(1, 0) == 1)
               queue_request(OP_CAPTURE, $urandom_range(SAMPLE_MAX, 0));
            pick = $urandom_range(99, 0);
            sweep_style = (pick < 60) ? STYLE_PLAIN :
                          (pick < 85) ? STYLE_BRIGHT : STYLE_DARK;
         end
         if ($urandom_range(99, 0) < 5) begin
            queue_request(OP_CAPTURE, $urandom_range(SAMPLE_MAX, 0));
         end else begin
            case (sweep_style)
               STYLE_BRIGHT: begin
                  if (next_slot >= CH_INNER_LEFT) sample = $urandom_range(SAMPLE_MAX, 600);
                  else sample = $urandom_range(SAMPLE_MAX, 0);
               end
               STYLE_DARK: begin
                  sample = $urandom_range(15, 0);
               end
               default: begin
                  pick = $urandom_range(7, 0);
                  if (pick == 0) sample = 0;
                  else if (pick == 1) sample = SAMPLE_MAX;
                  else if (pick < 4) sample = $urandom_range(31, 0);
                  else sample = $urandom_range(SAMPLE_MAX, 0);
               end
            endcase
            queue_request(OP_SAMPLE, sample);
         end
      end
   endtask

   // Waits (mid-cycle, after all updates) until nothing is queued, driven or
   // outstanding, then lets the pipeline settle.
   task automatic finish_phase();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(csr_reg_type idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_BITS'(value);
      case (idx)
         REG_ALPHA: cfg_alpha = ALPHA_BITS'(value);
         REG_NOISE: cfg_noise = sample_type'(value);
         REG_HOLD:  cfg_hold  = sample_type'(value);
         REG_INNER: cfg_inner = sample_type'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(int alpha, int noise, int hold, int inner);
      write_setting(REG_ALPHA, alpha);
      write_setting(REG_NOISE, noise);
      write_setting(REG_HOLD, hold);
      write_setting(REG_INNER, inner);
   endtask

   task automatic set_pace(int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   // ------------------------------------------------------ test sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings, full rate both sides.
      set_pace(0, 0);
      // capture with every level still zero: ambient stays zero
      queue_request(OP_CAPTURE, SAMPLE_MAX);
      // ambient zero: samples stored as-is; left/right tie at full scale,
      // down and both inner lit so the held flag fires
      queue_request(OP_SAMPLE, 300);
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      queue_request(OP_SAMPLE, 512);
      queue_request(OP_SAMPLE, 1);
      queue_request(OP_SAMPLE, 700);
      queue_request(OP_SAMPLE, 650);
      queue_request(OP_SAMPLE, 250);
      // ambient from back/left/right minimum, then smoothing with removal
      queue_request(OP_CAPTURE, 0);
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      queue_request(OP_SAMPLE, 0);
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      // capture in the middle of a sweep must not move the counter
      queue_request(OP_CAPTURE, 0);
      queue_request(OP_SAMPLE, 0);        // smoothed toward zero
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      queue_request(OP_SAMPLE, SAMPLE_MAX);
      queue_request(OP_SAMPLE, 0);
      finish_phase();

      // No smoothing memory, every threshold at zero; sender mostly idle.
      apply_settings(0, 0, 0, 0);
      set_pace(85, 0);
      queue_random(300);
      finish_phase();

      // Previous value only, thresholds at full scale; receiver stalls a lot.
      apply_settings(Q_ONE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      set_pace(0, 85);
      queue_random(300);
      finish_phase();

      // Alpha beyond one saturates; random thresholds; both sides idle.
      apply_settings((1 << ALPHA_BITS) - 1, $urandom_range(SAMPLE_MAX, 0),
                     $urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0));
      set_pace(31, 31);
      queue_random(350);
      finish_phase();

      // Random alpha, mid-range thresholds, full rate; the sender stops once
      // partway through until every outstanding response is back.
      apply_settings($urandom_range(Q_ONE, 0), $urandom_range(300, 0),
                     $urandom_range(800, 100), $urandom_range(800, 300));
      set_pace(0, 0);
      drain_point = accepted + 150;
      queue_random(400);
      finish_phase();

      // Back to the reset settings.
      apply_settings(ALPHA_RESET, NOISE_RESET, HOLD_RESET, INNER_RESET);
      set_pace(31, 31);
      queue_random(450);
      finish_phase();

      $display("Summary: %0d requests (%0d ambient captures), %0d responses checked.",
               accepted, captures, checked);
      $display("Summary: %0d sweep reports, %0d with target seen, %0d with target held.",
               sweeps, seen_sweeps, held_sweeps);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost response ends here.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout with %0d responses outstanding", expected_reports.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
